/* rtl/imu_angle_frame_parser_top_assert.svh */
// Assertion macros used by the parser core RTL.
// Each check is disabled while reset is asserted.
`ifndef IMU_ANGLE_FRAME_PARSER_TOP_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define IMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define IMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/imu_afp_pkg.sv */
package imu_afp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Decoded angle triple
  typedef struct packed {
    logic signed [15:0] angle_z;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_x;
  } angles_t;

  // Status from the parser core to the stream wrapper
  typedef struct packed {
    logic    emit;
    angles_t angles;
  } afp_status_t;

endpackage

/* rtl/imu_angle_frame_parser_top.sv */
// A good frame's last byte passes from the input register, and its angles into the result
// register that drives out_tvalid, provided the result register is free or drains.
// Throughput: one byte per cycle; a waiting result stalls only a byte that ends a good frame.
// The rate is set by the single input register and the single result register.
// Reset (rst_n low, synchronous) returns the parser to idle, waiting for a header,
// and empties both registers; frame bytes are not cleared.
module imu_angle_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] angle_x, [31:16] angle_y, [47:32] angle_z
);

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic                     out_valid_r, out_valid_nxt;
  imu_afp_pkg::angles_t     out_data_r;
  imu_afp_pkg::afp_status_t st;
  logic                     out_free;
  logic                     step;

  // A byte advances unless it completes a good frame while the result slot is full.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && (!st.emit || out_free);
  assign in_tready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  imu_afp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid_r),
    .step_i  (step),
    .byte_i  (in_byte_r),
    .st_o    (st)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (step && st.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && st.emit) begin
      out_data_r <= st.angles;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.angle_z, out_data_r.angle_y, out_data_r.angle_x};

endmodule

/* rtl/imu_afp_core.sv */
`include "imu_angle_frame_parser_top_assert.svh"

module imu_afp_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,  // a byte sits in the input register
  input  logic                      step_i,   // that byte is consumed this cycle
  input  logic [7:0]                byte_i,
  output imu_afp_pkg::afp_status_t  st_o
);

  logic [imu_afp_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic                          in_frame_r, in_frame_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    frame_store_r [imu_afp_pkg::FRAME_LEN];
  logic                          last_byte;
  logic                          good;

  // The last byte of a frame carries the checksum.
  assign last_byte = valid_i && in_frame_r && (byte_count_r == imu_afp_pkg::LAST_IDX);
  assign good      = (frame_store_r[1] == imu_afp_pkg::TYPE_ANGLE) && (sum_r == byte_i);

  always_comb begin
    st_o.emit           = last_byte && good;
    st_o.angles.angle_x = {frame_store_r[3], frame_store_r[2]};
    st_o.angles.angle_y = {frame_store_r[5], frame_store_r[4]};
    st_o.angles.angle_z = {frame_store_r[7], frame_store_r[6]};
  end

  // Frame tracking and running checksum over bytes ahead of the checksum byte.
  always_comb begin
    byte_count_nxt = byte_count_r;
    in_frame_nxt   = in_frame_r;
    sum_nxt        = sum_r;
    if (step_i) begin
      if (!in_frame_r) begin
        if (byte_i == imu_afp_pkg::HDR_BYTE) begin
          byte_count_nxt = imu_afp_pkg::CNT_W'(1);
          in_frame_nxt   = 1'b1;
          sum_nxt        = byte_i;
        end
      end else if (byte_count_r == imu_afp_pkg::LAST_IDX) begin
        byte_count_nxt = '0;
        in_frame_nxt   = 1'b0;
      end else begin
        byte_count_nxt = byte_count_r + imu_afp_pkg::CNT_W'(1);
        sum_nxt        = sum_r + byte_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      in_frame_r   <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      in_frame_r   <= in_frame_nxt;
    end
  end

  // Frame bytes and checksum need no reset.
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (step_i && (in_frame_r || (byte_i == imu_afp_pkg::HDR_BYTE))) begin
      frame_store_r[in_frame_r ? byte_count_r : '0] <= byte_i;
    end
  end

  `IMU_ASSERT_IMPL(a_idle_count, clk, rst_n, !in_frame_r, byte_count_r == '0)
  `IMU_ASSERT_IMPL(a_frame_count, clk, rst_n, in_frame_r,
                   byte_count_r != '0 && byte_count_r <= imu_afp_pkg::LAST_IDX)
  `IMU_ASSERT_IMPL(a_emit_last, clk, rst_n, st_o.emit,
                   valid_i && in_frame_r && byte_count_r == imu_afp_pkg::LAST_IDX)
  `IMU_ASSERT_NEXT(a_frame_close, clk, rst_n, step_i && last_byte, !in_frame_r)

endmodule
